### design/assert_macros.svh
// Assertion macros shared by the reassembler RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted.
`define DFR_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define DFR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### design/dfr_pkg.sv
// Shared types, codes and defaults for the datagram fragment reassembler.
`default_nettype none
package dfr_pkg;

    localparam int STORE_BYTES_DEF = 65536;
    localparam int FRAG_BYTES_DEF  = 1024;

    localparam int S_TDATA_W = 120;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 32;
    localparam int SIZE_W    = 17;
    localparam int IDX_W     = 16;

    localparam logic [1:0] REQ_FRAG    = 2'd0;
    localparam logic [1:0] REQ_READ    = 2'd1;
    localparam logic [1:0] REQ_RELEASE = 2'd2;

    localparam logic [1:0] PH_SYNC       = 2'd0;
    localparam logic [1:0] PH_INCOMPLETE = 2'd1;
    localparam logic [1:0] PH_READY      = 2'd2;

    typedef struct packed {
        logic [1:0]        phase;
        logic              rd_sel;
        logic [SIZE_W-1:0] size;
        logic              oversize;
        logic              released;
    } res_t;

endpackage
`default_nettype wire

### design/datagram_fragment_reassembler_top.sv
// Datagram fragment reassembler: in-order unit reassembly into a byte store.
//
// Accepts one transfer per clock (fragment byte, store read or release) for as
// long as the result side takes results; each transfer yields exactly one result,
// registered in the stage register and then in the output register. The rate is
// set by the single write port and the single registered read port of the byte
// store, each used by at most one transfer per clock; the gathering state lives
// in registers updated per transfer. The store needs no clearing after reset and
// only bytes of the current unit are ever read.
`default_nettype none
module datagram_fragment_reassembler_top
    import dfr_pkg::*;
#(
    parameter int STORE_BYTES = STORE_BYTES_DEF,
    parameter int FRAG_BYTES  = FRAG_BYTES_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // unit_num, frag_num, total_size, data_byte, read_index
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    // req_type
    input  wire logic [S_TUSER_W-1:0] s_tuser,
    input  wire logic                 s_tlast,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // phase, read_data, ready_size, oversize, released, zero pad
    output logic      [M_TDATA_W-1:0] m_tdata
);

    localparam int AW = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;

    logic          take;
    logic          mem_we, mem_re;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [7:0]    mem_wdata, mem_rdata;
    res_t          res;

    assign take = s_tvalid && s_tready;

    dfr_ctrl #(
        .STORE_BYTES (STORE_BYTES),
        .FRAG_BYTES  (FRAG_BYTES)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .take      (take),
        .req       (s_tuser[1:0]),
        .unum      (s_tdata[31:0]),
        .fnum      (s_tdata[63:32]),
        .total     (s_tdata[95:64]),
        .dbyte     (s_tdata[103:96]),
        .last      (s_tlast),
        .idx       (s_tdata[119:104]),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .res       (res)
    );

    dfr_store #(
        .STORE_BYTES (STORE_BYTES)
    ) u_store (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    dfr_out u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .take     (take),
        .res      (res),
        .rd_q     (mem_rdata),
        .in_ready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
`default_nettype wire

### design/dfr_store.sv
// Unit byte store: one write port, one registered read port.
`default_nettype none
module dfr_store
    import dfr_pkg::*;
#(
    parameter int STORE_BYTES = STORE_BYTES_DEF,
    localparam int AW = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1
) (
    input  wire logic          aclk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [7:0]    wdata,
    input  wire logic          re,
    input  wire logic [AW-1:0] raddr,
    output logic      [7:0]    rdata
);

    logic [7:0] mem [STORE_BYTES];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

### design/dfr_ctrl.sv
// Reassembly state and per-transfer next-state logic, store write and read requests.
`default_nettype none
module dfr_ctrl
    import dfr_pkg::*;
#(
    parameter int STORE_BYTES = STORE_BYTES_DEF,
    parameter int FRAG_BYTES  = FRAG_BYTES_DEF,
    localparam int AW = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             take,
    input  wire logic [1:0]       req,
    input  wire logic [31:0]      unum,
    input  wire logic [31:0]      fnum,
    input  wire logic [31:0]      total,
    input  wire logic [7:0]       dbyte,
    input  wire logic             last,
    input  wire logic [IDX_W-1:0] idx,
    output logic                  mem_we,
    output logic      [AW-1:0]    mem_waddr,
    output logic      [7:0]       mem_wdata,
    output logic                  mem_re,
    output logic      [AW-1:0]    mem_raddr,
    output res_t                  res
);

    `include "assert_macros.svh"

    localparam int CW = $clog2(STORE_BYTES + 1);
    localparam int OW = $clog2(FRAG_BYTES + 1);
    localparam int SW = (CW > SIZE_W) ? CW : SIZE_W;
    localparam int IW = (CW > IDX_W) ? CW : IDX_W;

    logic [1:0]    phase_reg, phase_next;
    logic [31:0]   unit_reg, unit_next;
    logic [31:0]   efrag_reg, efrag_next;
    logic [CW-1:0] gath_reg, gath_next;
    logic [OW-1:0] off_reg, off_next;
    logic          ovs_reg, ovs_next;

    logic          we, re, rel, first, in_frag;
    logic [AW-1:0] wa;
    logic [CW-1:0] size_out;
    logic [SW-1:0] size_ext;
    logic [IW-1:0] idx_ext;

    assign idx_ext = IW'(idx);

    always_comb begin
        phase_next = phase_reg;
        unit_next  = unit_reg;
        efrag_next = efrag_reg;
        gath_next  = gath_reg;
        off_next   = off_reg;
        ovs_next   = ovs_reg;
        we         = 1'b0;
        re         = 1'b0;
        rel        = 1'b0;
        wa         = gath_reg[AW-1:0];
        size_out   = gath_reg;
        first      = (off_reg == '0);
        in_frag    = (off_reg < OW'(FRAG_BYTES));
        unique case (req)
            REQ_FRAG: begin
                if (fnum == 32'd0 && first) begin
                    unit_next  = unum;
                    efrag_next = '0;
                    gath_next  = '0;
                    if (total > 32'(STORE_BYTES)) begin
                        ovs_next   = 1'b1;
                        phase_next = PH_SYNC;
                    end else begin
                        ovs_next   = 1'b0;
                        phase_next = PH_INCOMPLETE;
                    end
                end
                if (phase_next == PH_INCOMPLETE && unum == unit_next &&
                    fnum == efrag_next) begin
                    if (in_frag) begin
                        if (gath_next >= CW'(STORE_BYTES)) begin
                            ovs_next   = 1'b1;
                            phase_next = PH_SYNC;
                            gath_next  = '0;
                        end else begin
                            we        = 1'b1;
                            wa        = gath_next[AW-1:0];
                            gath_next = gath_next + 1'b1;
                        end
                    end
                    if (last && phase_next == PH_INCOMPLETE) begin
                        efrag_next = efrag_next + 32'd1;
                        if (32'(gath_next) == total) begin
                            phase_next = PH_READY;
                        end
                    end
                end
                if (last) begin
                    off_next = '0;
                end else if (in_frag) begin
                    off_next = off_reg + 1'b1;
                end
                size_out = gath_next;
            end
            REQ_READ: begin
                re = (phase_reg == PH_READY) && (idx_ext < IW'(gath_reg));
            end
            REQ_RELEASE: begin
                if (phase_reg == PH_READY) begin
                    rel        = 1'b1;
                    phase_next = PH_SYNC;
                    gath_next  = '0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_SYNC;
            unit_reg  <= '0;
            efrag_reg <= '0;
            gath_reg  <= '0;
            off_reg   <= '0;
            ovs_reg   <= 1'b0;
        end else if (take) begin
            phase_reg <= phase_next;
            unit_reg  <= unit_next;
            efrag_reg <= efrag_next;
            gath_reg  <= gath_next;
            off_reg   <= off_next;
            ovs_reg   <= ovs_next;
        end
    end

    assign size_ext  = SW'(size_out);
    assign mem_we    = take && we;
    assign mem_waddr = wa;
    assign mem_wdata = dbyte;
    assign mem_re    = take && re;
    assign mem_raddr = idx_ext[AW-1:0];

    always_comb begin
        res.phase    = phase_next;
        res.rd_sel   = re;
        res.size     = size_ext[SIZE_W-1:0];
        res.oversize = ovs_next;
        res.released = rel;
    end

    // a stored byte always advances the count past its own address
    `DFR_ASSERT(a_write_advances, aclk, aresetn, mem_we |=> (gath_reg - 1'b1) == CW'($past(mem_waddr)), "count did not follow store write")
    `DFR_ASSERT(a_ready_not_ovs, aclk, aresetn, (phase_reg == PH_READY) |-> !ovs_reg, "ready unit flagged oversize")
    `DFR_ASSERT(a_count_bound, aclk, aresetn, gath_reg <= CW'(STORE_BYTES), "gathered count beyond store")
    `DFR_ASSERT(a_read_ready, aclk, aresetn, mem_re |-> (phase_reg == PH_READY) && !mem_we, "store read outside ready unit")

endmodule
`default_nettype wire

### design/dfr_out.sv
// Result pipeline: store-read stage and output register with stall control.
`default_nettype none
module dfr_out
    import dfr_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 take,
    input  wire res_t                 res,
    input  wire logic [7:0]           rd_q,
    output logic                      in_ready,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic      [M_TDATA_W-1:0] m_tdata
);

    `include "assert_macros.svh"

    logic                 p1_v_reg;
    res_t                 p1_reg;
    logic                 out_v_reg;
    logic [M_TDATA_W-1:0] out_reg, out_next;
    logic                 load_out;
    logic [7:0]           rd_byte;

    assign load_out = p1_v_reg && (!out_v_reg || m_tready);
    assign in_ready = !p1_v_reg || load_out;
    assign rd_byte  = p1_reg.rd_sel ? rd_q : 8'd0;
    assign out_next = M_TDATA_W'({p1_reg.released, p1_reg.oversize, p1_reg.size,
                                  rd_byte, p1_reg.phase});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
        end else begin
            if (take) begin
                p1_v_reg <= 1'b1;
            end else if (load_out) begin
                p1_v_reg <= 1'b0;
            end
            if (load_out) begin
                out_v_reg <= 1'b1;
            end else if (m_tready) begin
                out_v_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            p1_reg <= res;
        end
        if (load_out) begin
            out_reg <= out_next;
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = out_reg;

    `DFR_ASSERT(a_take_fills, aclk, aresetn, take |=> p1_v_reg, "accepted transfer lost")
    `DFR_ASSERT(a_no_overrun, aclk, aresetn, take |-> in_ready, "transfer taken while stage full")

endmodule
`default_nettype wire

### sim/datagram_fragment_reassembler_top_tb.sv
// Self-checking testbench for the datagram fragment reassembler: directed and random traffic.
module datagram_fragment_reassembler_top_tb;
    import dfr_pkg::*;

    typedef struct {
        logic [1:0]  req;
        logic [31:0] unit_num;
        logic [31:0] frag_num;
        logic [31:0] total_size;
        logic [7:0]  data_byte;
        logic        frag_last;
        logic [15:0] read_index;
    } xfer_t;

    typedef struct {
        logic [1:0]        phase;
        logic [7:0]        read_data;
        logic [SIZE_W-1:0] ready_size;
        logic              oversize;
        logic              released;
    } outcome_t;

    typedef enum int {
        FLAW_NONE, FLAW_WRONG_UNIT, FLAW_OUT_OF_ORDER, FLAW_DUP, FLAW_SIZE, FLAW_HUGE,
        FLAW_RESTART
    } flaw_e;

    localparam logic [1:0] REQ_UNUSED = 2'd3;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int RANDOM_XFERS   = 80;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic [S_TUSER_W-1:0] s_tuser  = '0;
    logic                 s_tlast  = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    datagram_fragment_reassembler_top u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #4 aclk = ~aclk;

    // gathering state, mirrored
    logic [1:0]  mdl_phase     = PH_SYNC;
    logic [31:0] mdl_unit      = '0;
    logic [31:0] mdl_next_frag = '0;
    int unsigned mdl_gathered  = 0;
    int unsigned mdl_offset    = 0;
    logic        mdl_oversize  = 1'b0;
    logic [7:0]  mdl_store [STORE_BYTES_DEF];

    xfer_t       pending_xfers[$];
    outcome_t    expected_results[$];
    xfer_t       cur_xfer;
    int unsigned xfers_sent      = 0;
    int unsigned results_checked = 0;
    int unsigned mismatches      = 0;
    int unsigned units_released  = 0;
    int unsigned stored_reads    = 0;
    int          send_gap        = 0;
    int          take_gap        = 0;
    logic        send_burst      = 1'b0;
    logic        take_burst      = 1'b0;
    int          idle_cycles     = 0;

    function automatic outcome_t reassemble_step(input xfer_t x);
        outcome_t r;
        logic     starts;
        logic     in_frag;
        r.read_data = '0;
        r.released  = 1'b0;
        case (x.req)
            REQ_FRAG: begin
                starts  = (mdl_offset == 0);
                in_frag = (mdl_offset < FRAG_BYTES_DEF);
                if (x.frag_num == 0 && starts) begin
                    mdl_unit      = x.unit_num;
                    mdl_next_frag = '0;
                    mdl_gathered  = 0;
                    mdl_oversize  = (x.total_size > STORE_BYTES_DEF);
                    mdl_phase     = mdl_oversize ? PH_SYNC : PH_INCOMPLETE;
                end
                if (mdl_phase == PH_INCOMPLETE && x.unit_num == mdl_unit &&
                    x.frag_num == mdl_next_frag) begin
                    if (in_frag) begin
                        if (mdl_gathered >= STORE_BYTES_DEF) begin
                            mdl_oversize = 1'b1;
                            mdl_phase    = PH_SYNC;
                            mdl_gathered = 0;
                        end else begin
                            mdl_store[mdl_gathered] = x.data_byte;
                            mdl_gathered++;
                        end
                    end
                    if (x.frag_last && mdl_phase == PH_INCOMPLETE) begin
                        mdl_next_frag++;
                        if (mdl_gathered == x.total_size)
                            mdl_phase = PH_READY;
                    end
                end
                if (x.frag_last)
                    mdl_offset = 0;
                else if (in_frag)
                    mdl_offset++;
                r.ready_size = SIZE_W'(mdl_gathered);
            end
            REQ_READ: begin
                if (mdl_phase == PH_READY && x.read_index < mdl_gathered) begin
                    r.read_data = mdl_store[x.read_index];
                    stored_reads++;
                end
                r.ready_size = SIZE_W'(mdl_gathered);
            end
            REQ_RELEASE: begin
                r.ready_size = SIZE_W'(mdl_gathered);
                if (mdl_phase == PH_READY) begin
                    r.released   = 1'b1;
                    mdl_phase    = PH_SYNC;
                    mdl_gathered = 0;
                    units_released++;
                end
            end
            default: r.ready_size = SIZE_W'(mdl_gathered);
        endcase
        r.phase    = mdl_phase;
        r.oversize = mdl_oversize;
        return r;
    endfunction

    function automatic xfer_t noise_xfer();
        xfer_t x;
        x.req        = 2'($urandom_range(0, 3));
        x.unit_num   = $urandom;
        x.frag_num   = $urandom;
        x.total_size = $urandom;
        x.data_byte  = 8'($urandom);
        x.frag_last  = ($urandom_range(0, 3) != 0);
        x.read_index = 16'($urandom);
        return x;
    endfunction

    task automatic add_frag_byte(input logic [31:0] un, input logic [31:0] fn,
                                 input logic [31:0] tot, input logic [7:0] data,
                                 input logic last);
        xfer_t x;
        x            = noise_xfer();
        x.req        = REQ_FRAG;
        x.unit_num   = un;
        x.frag_num   = fn;
        x.total_size = tot;
        x.data_byte  = data;
        x.frag_last  = last;
        pending_xfers.push_back(x);
    endtask

    task automatic add_fragment(input logic [31:0] un, input logic [31:0] fn,
                                input logic [31:0] tot, input int len);
        for (int i = 0; i < len; i++)
            add_frag_byte(un, fn, tot, 8'($urandom), i == len - 1);
    endtask

    task automatic add_request(input logic [1:0] req, input logic [15:0] idx);
        xfer_t x;
        x            = noise_xfer();
        x.req        = req;
        x.read_index = idx;
        pending_xfers.push_back(x);
    endtask

    // one unit split into fragments, optionally broken, then reads and optional releases
    task automatic add_unit(input logic [31:0] un, input int total, input int fsize,
                            input flaw_e flaw);
        int          done;
        int          len;
        int          f;
        int          flaw_at;
        logic        flaw_done;
        logic [31:0] tot_field;
        tot_field = total;
        if (flaw == FLAW_SIZE)
            tot_field = ($urandom_range(0, 1) == 1) ? total + 1 : total - 1;
        if (flaw == FLAW_HUGE)
            tot_field = $urandom_range(32'hFFFF_FFFF, STORE_BYTES_DEF + 1);
        flaw_at   = $urandom_range(0, (total - 1) / fsize);
        flaw_done = 1'b0;
        done      = 0;
        f         = 0;
        while (done < total) begin
            len = (total - done < fsize) ? total - done : fsize;
            if (f == flaw_at && !flaw_done) begin
                flaw_done = 1'b1;
                case (flaw)
                    FLAW_WRONG_UNIT:   add_fragment(un + 1, f, tot_field, len);
                    FLAW_OUT_OF_ORDER: add_fragment(un, f + 1, tot_field, len);
                    FLAW_RESTART: begin
                        if (f > 0) begin
                            done = 0;
                            f    = 0;
                            continue;
                        end
                    end
                    default: ;
                endcase
            end
            add_fragment(un, f, tot_field, len);
            if (flaw == FLAW_DUP && f == flaw_at)
                add_fragment(un, f, tot_field, len);
            done += len;
            f++;
        end
        repeat ($urandom_range(1, 4))
            add_request(REQ_READ, ($urandom_range(0, 7) == 0) ? 16'($urandom)
                                                              : 16'($urandom_range(0, total)));
        if ($urandom_range(0, 4) != 0)
            add_request(REQ_RELEASE, 16'($urandom));
        if ($urandom_range(0, 7) == 0)
            add_request(REQ_RELEASE, 16'($urandom));
    endtask

    task automatic compare_field(input string fname, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, actual %0d", fname, want, got);
            mismatches++;
        end
    endtask

    task automatic check_result(input logic [M_TDATA_W-1:0] word);
        outcome_t want;
        if (expected_results.size() == 0) begin
            $error("result transfer with nothing expected: %h", word);
            mismatches++;
        end else begin
            want = expected_results.pop_front();
            results_checked++;
            compare_field("phase", 32'(want.phase), 32'(word[1:0]));
            compare_field("read_data", 32'(want.read_data), 32'(word[9:2]));
            compare_field("ready_size", 32'(want.ready_size), 32'(word[26:10]));
            compare_field("oversize", 32'(want.oversize), 32'(word[27]));
            compare_field("released", 32'(want.released), 32'(word[28]));
        end
    endtask

    // input driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_results.push_back(reassemble_step(cur_xfer));
                xfers_sent++;
                if ($urandom_range(0, 63) == 0)
                    send_burst = !send_burst;
                send_gap = send_burst ? 0 : $urandom_range(0, 3);
            end
            if (!s_tvalid || s_tready) begin
                if (send_gap > 0 || pending_xfers.size() == 0) begin
                    if (send_gap > 0)
                        send_gap--;
                    s_tvalid <= 1'b0;
                end else begin
                    cur_xfer = pending_xfers.pop_front();
                    s_tdata  <= {cur_xfer.read_index, cur_xfer.data_byte, cur_xfer.total_size,
                                 cur_xfer.frag_num, cur_xfer.unit_num};
                    s_tuser  <= cur_xfer.req;
                    s_tlast  <= cur_xfer.frag_last;
                    s_tvalid <= 1'b1;
                end
            end
        end
    end

    // result monitor
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                check_result(m_tdata);
                if ($urandom_range(0, 63) == 0)
                    take_burst = !take_burst;
                take_gap = take_burst ? 0 : $urandom_range(0, 3);
            end
            if (take_gap > 0) begin
                take_gap--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
            $display("FAIL datagram_fragment_reassembler_top");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int          base;
        int          pick;
        int          directed_count;
        int          item_count;
        logic [31:0] un;
        flaw_e       flaw;

        // directed
        add_request(REQ_RELEASE, 16'h0000);
        add_request(REQ_READ, 16'hFFFF);
        add_request(REQ_UNUSED, 16'h0000);
        add_frag_byte(32'h0, 32'h5, 32'h10, 8'h00, 1'b1);
        add_frag_byte(32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 8'hFF, 1'b1);
        add_frag_byte(32'hFFFF_FFFF, 32'h1, 32'hFFFF_FFFF, 8'h11, 1'b1);
        add_frag_byte(32'h0, 32'h0, 32'd3, 8'hFF, 1'b0);
        add_frag_byte(32'h0, 32'h0, 32'd3, 8'h00, 1'b1);
        add_frag_byte(32'h1, 32'h1, 32'd3, 8'h55, 1'b1);
        add_frag_byte(32'h0, 32'h2, 32'd3, 8'h66, 1'b1);
        add_frag_byte(32'h0, 32'h1, 32'd3, 8'hA5, 1'b1);
        add_request(REQ_READ, 16'd0);
        add_request(REQ_READ, 16'd2);
        add_request(REQ_READ, 16'd3);
        // resync while ready, then fragment 0 byte past offset 0
        add_frag_byte(32'hFFFF_FFFE, 32'h0, 32'd2, 8'h5A, 1'b0);
        add_frag_byte(32'hFFFF_FFFE, 32'h0, 32'd2, 8'hC3, 1'b1);
        add_request(REQ_READ, 16'd1);
        add_request(REQ_RELEASE, 16'd0);
        add_request(REQ_RELEASE, 16'd0);
        add_request(REQ_READ, 16'd0);
        // count overshoot
        add_frag_byte(32'd7, 32'h0, 32'd0, 8'h80, 1'b1);
        add_frag_byte(32'd7, 32'h1, 32'd1, 8'h01, 1'b1);
        // size at and just above the store
        add_frag_byte(32'd9, 32'h0, STORE_BYTES_DEF, 8'h7F, 1'b1);
        add_frag_byte(32'd9, 32'h0, STORE_BYTES_DEF + 1, 8'h3C, 1'b1);
        directed_count = pending_xfers.size();

        // random units, mostly well formed
        base = pending_xfers.size();
        while (pending_xfers.size() - base < RANDOM_XFERS) begin
            pick = $urandom_range(0, 99);
            if (pick < 12) begin
                repeat ($urandom_range(1, 4))
                    pending_xfers.push_back(noise_xfer());
            end else begin
                un   = ($urandom_range(0, 1) == 1) ? $urandom : $urandom_range(0, 3);
                flaw = (pick < 60) ? FLAW_NONE
                                   : flaw_e'($urandom_range(FLAW_WRONG_UNIT, FLAW_RESTART));
                add_unit(un, $urandom_range(1, 48), $urandom_range(1, 12), flaw);
            end
        end

        // long fragment: bytes past the fragment limit are dropped
        un = $urandom;
        add_fragment(un, 0, FRAG_BYTES_DEF, FRAG_BYTES_DEF + $urandom_range(1, 8));
        add_request(REQ_READ, 16'(FRAG_BYTES_DEF - 1));
        add_request(REQ_READ, 16'(FRAG_BYTES_DEF));
        add_request(REQ_RELEASE, 16'd0);
        add_unit($urandom, $urandom_range(1, 48), $urandom_range(1, 12), FLAW_NONE);
        item_count = pending_xfers.size();

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        while (xfers_sent != item_count || expected_results.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("%0d transfers in (%0d directed), %0d results checked, %0d mismatches",
                 xfers_sent, directed_count, results_checked, mismatches);
        $display("%0d units released, %0d reads returned stored bytes, incl. one long fragment",
                 units_released, stored_reads);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("PASS datagram_fragment_reassembler_top");
        else
            $display("FAIL datagram_fragment_reassembler_top");
        $finish;
    end

endmodule
